>>> src/second_chance_page_replacer_assert.svh
// Assertion macros used by the page replacer RTL.
// They are empty when SYNTHESIS is defined.
`ifndef SECOND_CHANCE_PAGE_REPLACER_ASSERT_SVH
`define SECOND_CHANCE_PAGE_REPLACER_ASSERT_SVH
`ifndef SYNTHESIS
`define SCPR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("page replacer assertion failed");
`define SCPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page replacer assertion failed");
`else
`define SCPR_ASSERT(label, prop)
`define SCPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/scpr_pkg.sv
// ----------------------------------------------------------------------------
// scpr_pkg
// Constants, types and helpers of the second-chance page replacer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpr_pkg;

	localparam int FRAME_COUNT = 4;
	localparam int PAGE_BITS   = 16;
	localparam int FRAME_BITS  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int PORT_PAGE_W = 16;
	localparam int PORT_FRAME_W = 2;

	typedef logic [PAGE_BITS-1:0]  tag_t;
	typedef logic [FRAME_BITS-1:0] frame_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_EVICT
	} state_t;

	localparam frame_t LAST_FRAME = FRAME_BITS'(FRAME_COUNT - 1);

	function automatic frame_t next_frame(input frame_t f);
		frame_t r;
		if (f == LAST_FRAME) begin
			r = '0;
		end else begin
			r = f + frame_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/second_chance_page_replacer.sv
// ----------------------------------------------------------------------------
// second_chance_page_replacer
// Clock (second-chance) page replacement over a small frame table.
// ----------------------------------------------------------------------------
// A page reference word is taken on page_number at a clock edge where start
// is high and busy is low. One result word follows, shown for a single cycle
// with done high: hit, frame_index, evicted_valid and evicted_page. The
// receiver cannot hold it off, and busy stays high until done is shown, so
// the next word may be started in the cycle that shows done.
// The page tags live in a synchronous memory with one read port, read one
// frame a cycle; the valid and reference bits sit in flip-flops.
// A lookup reads the tags frame by frame from frame 0 and ends on the first
// valid match. A miss reads every frame; then the hand steps on one frame
// at a time (1 to FRAME_COUNT + 1 frames, the last of which reads the victim
// tag), the new tag is written and done is shown.
// The tag lookup and the hand sweep set how long a word takes to finish.
// Reset clears all valid and reference bits and parks the hand on the last
// frame; no clearing pass is needed, as a tag is only read when valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "second_chance_page_replacer_assert.svh"

module second_chance_page_replacer
	import scpr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [PORT_PAGE_W-1:0]  page_number,
	output logic                         done,
	output logic                         hit,
	output logic [PORT_FRAME_W-1:0]      frame_index,
	output logic                         evicted_valid,
	output logic [PORT_PAGE_W-1:0]       evicted_page
);

	tag_t   tag_mem [FRAME_COUNT];
	tag_t   rdata_s1;

	state_t state_q, state_d;
	tag_t   page_q;
	frame_t idx_q;
	frame_t hand_q;
	logic [FRAME_COUNT-1:0] valid_q;
	logic [FRAME_COUNT-1:0] ref_q;

	logic   done_q, hit_q, ev_valid_q;
	frame_t frame_q;
	logic [PORT_PAGE_W-1:0] ev_page_q;

	logic   rd_en, wr_en;
	frame_t rd_addr;
	logic   accept, tag_match;
	frame_t cand;

	assign accept    = start && (state_q == ST_IDLE);
	assign tag_match = valid_q[idx_q] && (rdata_s1 == page_q);
	assign cand      = next_frame(hand_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (tag_match) state_d = ST_IDLE;
				else if (idx_q == LAST_FRAME) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (!ref_q[cand]) state_d = ST_EVICT;
			end
			ST_EVICT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en = start;
			end
			ST_LOOKUP: begin
				rd_en   = !tag_match && (idx_q != LAST_FRAME);
				rd_addr = idx_q + frame_t'(1);
			end
			ST_SWEEP: begin
				rd_en   = !ref_q[cand];
				rd_addr = cand;
			end
			ST_EVICT: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_s1 <= tag_mem[rd_addr];
		if (wr_en) tag_mem[hand_q] <= page_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			hand_q  <= LAST_FRAME;
			valid_q <= '0;
			ref_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
				end
				ST_LOOKUP: begin
					if (tag_match) begin
						ref_q[idx_q] <= 1'b1;
						done_q       <= 1'b1;
					end else begin
						idx_q <= idx_q + frame_t'(1);
					end
				end
				ST_SWEEP: begin
					// A frame with its bit set gets a second chance and is passed over.
					hand_q <= cand;
					if (ref_q[cand]) ref_q[cand] <= 1'b0;
				end
				ST_EVICT: begin
					valid_q[hand_q] <= 1'b1;
					ref_q[hand_q]   <= 1'b1;
					done_q          <= 1'b1;
				end
				default: begin
					idx_q <= '0;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) page_q <= PAGE_BITS'(page_number);
		if (state_q == ST_LOOKUP && tag_match) begin
			hit_q      <= 1'b1;
			frame_q    <= idx_q;
			ev_valid_q <= 1'b0;
			ev_page_q  <= '0;
		end else if (state_q == ST_EVICT) begin
			hit_q      <= 1'b0;
			frame_q    <= hand_q;
			ev_valid_q <= valid_q[hand_q];
			ev_page_q  <= valid_q[hand_q] ? PORT_PAGE_W'(rdata_s1) : '0;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = PORT_FRAME_W'(frame_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;

	`SCPR_ASSERT_NEXT(a_no_done_after_accept, accept, !done_q)
	`SCPR_ASSERT(a_frame_resident, !done_q || (valid_q[frame_q] && ref_q[frame_q]))
	`SCPR_ASSERT(a_hit_no_evict, !(done_q && hit_q) || (!ev_valid_q && ev_page_q == '0))
	`SCPR_ASSERT_NEXT(a_evict_writes, state_q == ST_EVICT, done_q && !hit_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the second-chance page replacer.
// A queue of page references is sent in random bursts over the start/busy
// handshake. Each accepted word runs through a behavioural clock-replacement
// model kept in the bench. The expected result is compared field by field
// with the word that the block shows on done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import scpr_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 3 * FRAME_COUNT + 8;
	localparam int REF_TOTAL = 1750;

	typedef logic [PORT_PAGE_W-1:0] page_word_t;

	typedef struct packed {
		logic                    hit;
		logic [PORT_FRAME_W-1:0] frame;
		logic                    ev_valid;
		page_word_t              ev_page;
	} page_outcome_t;

	typedef struct {
		page_word_t page;
		bit         wait_idle;
	} page_ref_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	page_word_t page_number = '0;
	logic       busy;
	logic       done;
	logic       hit;
	logic [PORT_FRAME_W-1:0] frame_index;
	logic       evicted_valid;
	page_word_t evicted_page;

	// Bench copy of the frame table.
	tag_t resident_tag[FRAME_COUNT];
	bit   resident_valid[FRAME_COUNT];
	bit   second_chance[FRAME_COUNT];
	int   hand = FRAME_COUNT - 1;

	page_ref_t     refs_to_send[$];
	page_outcome_t outcomes_due[$];
	int            refs_issued = 0;
	int            results_seen = 0;
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            gap_cnt = 0;
	int            burst_left = 0;

	second_chance_page_replacer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.done          (done),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Looks the page up and, on a miss, sweeps the hand to a victim frame.
	function automatic page_outcome_t reference_page(input page_word_t page);
		page_outcome_t r;
		tag_t          tag;
		bit            found;
		int            slot;
		r = '0;
		tag = tag_t'(page);
		found = 1'b0;
		slot = 0;
		for (int f = 0; f < FRAME_COUNT; f++) begin
			if (!found && resident_valid[f] && resident_tag[f] == tag) begin
				found = 1'b1;
				slot = f;
			end
		end
		if (found) begin
			second_chance[slot] = 1'b1;
			r.hit = 1'b1;
		end else begin
			// With every bit set the sweep goes once round and lands on the frame after the hand.
			for (int steps = 1; steps <= FRAME_COUNT + 1; steps++) begin
				hand = (hand >= FRAME_COUNT - 1) ? 0 : hand + 1;
				if (!second_chance[hand] || steps > FRAME_COUNT) begin
					break;
				end
				second_chance[hand] = 1'b0;
			end
			slot = hand;
			if (resident_valid[slot]) begin
				r.ev_valid = 1'b1;
				r.ev_page = PORT_PAGE_W'(resident_tag[slot]);
			end
			resident_tag[slot] = tag;
			resident_valid[slot] = 1'b1;
			second_chance[slot] = 1'b1;
		end
		r.frame = PORT_FRAME_W'(slot);
		return r;
	endfunction

	task automatic queue_ref(input page_word_t page, input bit wait_idle);
		page_ref_t item;
		item.page = page;
		item.wait_idle = wait_idle;
		refs_to_send.push_back(item);
	endtask

	task automatic check_field(input string field, input page_word_t want,
			input page_word_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Driver: presents one word at a time, in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic       accepted;
		logic       start_nx;
		page_word_t page_nx;
		int         outstanding;
		if (!arst_n) begin
			start <= 1'b0;
			page_number <= '0;
		end else begin
			accepted = start && !busy;
			start_nx = start;
			page_nx = page_number;
			outstanding = refs_issued - results_seen;
			if (accepted) begin
				outcomes_due.push_back(reference_page(page_number));
				refs_issued <= refs_issued + 1;
				outstanding++;
				start_nx = 1'b0;
				if (burst_left == 0) begin
					burst_left = $urandom_range(0, 40);
					gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
				end else begin
					burst_left--;
				end
			end
			if (!start_nx) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (refs_to_send.size() != 0 &&
						(!refs_to_send[0].wait_idle || outstanding == 0)) begin
					start_nx = 1'b1;
					page_nx = refs_to_send[0].page;
					refs_to_send.pop_front();
				end
			end
			start <= start_nx;
			page_number <= page_nx;
		end
	end

	// Monitor: every word shown on done must match the oldest expectation.
	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (outcomes_due.size() == 0) begin
				$display("%0t: result with nothing expected, actual hit %0b frame %0d ev %0b %0h",
					$time, hit, frame_index, evicted_valid, evicted_page);
				mismatches++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("hit", page_word_t'(want.hit), page_word_t'(hit));
				check_field("frame_index", page_word_t'(want.frame), page_word_t'(frame_index));
				check_field("evicted_valid", page_word_t'(want.ev_valid),
					page_word_t'(evicted_valid));
				check_field("evicted_page", want.ev_page, evicted_page);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		page_word_t pool[8];
		int         pool_size;
		int         sent;
		int         pick;
		page_word_t page;
		for (int f = 0; f < FRAME_COUNT; f++) begin
			resident_tag[f] = '0;
			resident_valid[f] = 1'b0;
			second_chance[f] = 1'b0;
		end

		// Empty frames never match, not even page 0; they fill in hand order.
		queue_ref(16'h0000, 1'b0);
		queue_ref(16'h0000, 1'b0);
		queue_ref(16'hFFFF, 1'b0);
		queue_ref(16'h8000, 1'b0);
		queue_ref(16'h0001, 1'b0);
		// All bits set: a full sweep evicts page 0 from frame 0.
		queue_ref(16'h7FFF, 1'b1);
		queue_ref(16'hFFFF, 1'b0);
		queue_ref(16'h8000, 1'b0);
		queue_ref(16'h0001, 1'b0);
		queue_ref(16'h7FFF, 1'b0);
		queue_ref(16'h5555, 1'b0);
		queue_ref(16'hAAAA, 1'b0);
		queue_ref(16'h0000, 1'b0);
		queue_ref(16'h0001, 1'b0);
		queue_ref(16'h00FF, 1'b0);
		queue_ref(16'hFF00, 1'b0);
		queue_ref(16'h5555, 1'b0);
		queue_ref(16'h1234, 1'b0);
		sent = 18;

		// Random part: a small working set, changed now and then, keeps hits and
		// misses mixed; a share of fully random pages walks every bit.
		pool_size = 0;
		while (sent < REF_TOTAL) begin
			if (pool_size == 0 || $urandom_range(0, 79) == 0) begin
				pool_size = $urandom_range(2, 8);
				for (int k = 0; k < 8; k++) begin
					pool[k] = ($urandom_range(0, 1) == 0) ? page_word_t'($urandom_range(0, 15))
						: page_word_t'($urandom);
				end
				queue_ref(pool[0], ($urandom_range(0, 2) == 0) || sent == 18);
				sent++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				page = pool[$urandom_range(0, pool_size - 1)];
			end else if (pick < 88) begin
				page = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
			end else begin
				page = page_word_t'($urandom);
			end
			queue_ref(page, 1'b0);
			sent++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (refs_to_send.size() != 0 || start || refs_issued != results_seen);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && outcomes_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/scpr_pkg.sv
src/second_chance_page_replacer.sv
bench/tb_top.sv
